@@ sv/skf_pkg.sv @@
// skf_pkg: shared widths, reset values, register indexes, FSM encoding and the
// command/status structs of the scalar Kalman filter.
// No dependencies; imported by skf_ctrl, skf_datapath and scalar_kalman_filter.
`default_nettype none

package skf_pkg;

    // Format of samples and of the fixed-point state
    localparam int SAMPLE_WIDTH = 16;
    localparam int FRAC_BITS    = 16;
    localparam int MEAS_W       = 16;
    localparam int DATA_W       = 32;

    // Gain is Q0.GAIN_BITS; one extra bit holds exactly one
    localparam int GAIN_BITS = 16;
    localparam int GAIN_W    = GAIN_BITS + 1;

    // Divider and multiplier widths
    localparam int DEN_W     = DATA_W + 1;
    localparam int REM_W     = DATA_W + 2;
    localparam int PROD_W    = DATA_W + GAIN_W;
    localparam int DIV_STEPS = GAIN_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [GAIN_W-1:0] GAIN_ONE  = GAIN_W'(1) << GAIN_BITS;
    localparam logic [PROD_W-1:0] GAIN_HALF = PROD_W'(1) << (GAIN_BITS - 1);

    localparam logic [MEAS_W-1:0] SAMPLE_MASK = MEAS_W'((64'd1 << SAMPLE_WIDTH) - 64'd1);
    localparam logic [63:0]       DATA_MAX    = (64'd1 << DATA_W) - 64'd1;

    // Configuration registers
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE    = CFG_IDX_W'(1);

    localparam logic [DATA_W-1:0] PROCESS_NOISE_RESET = DATA_W'(6554);
    localparam logic [DATA_W-1:0] MEAS_NOISE_RESET    = DATA_W'(65536);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_PRED = 8'b0000_0010,
        S_DEN  = 8'b0000_0100,
        S_DIV  = 8'b0000_1000,
        S_MULX = 8'b0001_0000,
        S_UPDX = 8'b0010_0000,
        S_UPDP = 8'b0100_0000,
        S_LOAD = 8'b1000_0000
    } t_state;

    typedef struct packed {
        logic load_in;
        logic pred;
        logic den;
        logic div_step;
        logic mulx;
        logic updx;
        logic updp;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic div_last;
    } t_status;

endpackage

`default_nettype wire

@@ sv/skf_datapath.sv @@
// skf_datapath: configuration registers, filter state, serial gain divider,
// shared 17x32 multiplier and the output word register.
// Depends on skf_pkg; driven by commands from skf_ctrl.
`default_nettype none

module skf_datapath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [skf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [skf_pkg::DATA_W-1:0]    i_cfg_data,
    input  wire logic [skf_pkg::MEAS_W-1:0]    i_measurement,
    input  wire skf_pkg::t_cmd                 i_cmd,
    output skf_pkg::t_status                   o_status,
    output logic      [skf_pkg::DATA_W-1:0]    o_estimate,
    output logic      [skf_pkg::GAIN_W-1:0]    o_gain
);
    import skf_pkg::*;

    logic [DATA_W-1:0] r_q, r_r, r_est, r_cov;
    logic [DATA_W-1:0] r_sample, r_pm, r_diff;
    logic [DEN_W-1:0]  r_den;
    logic              r_den_zero, r_dir;
    logic [REM_W-1:0]  r_rem;
    logic [GAIN_W-1:0] r_quo, r_gain;
    logic [STEP_W-1:0] r_step;
    logic [PROD_W-1:0] r_prod;
    logic [DATA_W-1:0] r_out_est;
    logic [GAIN_W-1:0] r_out_gain;

    logic [MEAS_W-1:0] sample;
    logic [63:0]       scaled;
    logic [DATA_W-1:0] scaled_sat;
    logic [DATA_W:0]   pm_sum;
    logic [DATA_W-1:0] pm_sat;
    logic [DEN_W-1:0]  den_sum;
    logic              ge;
    logic [REM_W-1:0]  rem_diff, rem_keep;
    logic [GAIN_W-1:0] gain_eff, mul_a;
    logic [DATA_W-1:0] mul_b;
    logic [PROD_W-1:0] product, prod_rnd;
    logic [DATA_W-1:0] rounded, est_next;

    always_comb begin
        sample     = i_measurement & SAMPLE_MASK;
        scaled     = 64'(sample) << FRAC_BITS;
        scaled_sat = (scaled > DATA_MAX) ? '1 : scaled[DATA_W-1:0];

        // predicted covariance, saturating
        pm_sum = {1'b0, r_cov} + {1'b0, r_q};
        pm_sat = pm_sum[DATA_W] ? '1 : pm_sum[DATA_W-1:0];
        den_sum = {1'b0, r_pm} + {1'b0, r_r};

        // one restoring division step
        ge       = r_rem >= REM_W'(r_den);
        rem_diff = r_rem - REM_W'(r_den);
        rem_keep = ge ? rem_diff : r_rem;

        // zero denominator gives zero gain
        if (r_den_zero) begin
            gain_eff = '0;
        end else if (r_quo > GAIN_ONE) begin
            gain_eff = GAIN_ONE;
        end else begin
            gain_eff = r_quo;
        end

        // shared multiplier: gain*|d| first, then (1-gain)*pm
        if (i_cmd.mulx) begin
            mul_a = gain_eff;
            mul_b = r_diff;
        end else begin
            mul_a = GAIN_ONE - r_gain;
            mul_b = r_pm;
        end
        product = PROD_W'(mul_a) * PROD_W'(mul_b);

        prod_rnd = (r_prod + GAIN_HALF) >> GAIN_BITS;
        rounded  = prod_rnd[DATA_W-1:0];
        est_next = r_dir ? (r_est + rounded) : (r_est - rounded);
    end

    assign o_status.div_last = (r_step == STEP_W'(DIV_STEPS - 1));

    // Configuration and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q   <= PROCESS_NOISE_RESET;
            r_r   <= MEAS_NOISE_RESET;
            r_est <= '0;
            r_cov <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_PROCESS_NOISE: r_q <= i_cfg_data;
                    CFG_MEAS_NOISE:    r_r <= i_cfg_data;
                    default:           ;
                endcase
            end
            if (i_cmd.updx) begin
                r_est <= est_next;
            end
            if (i_cmd.updp) begin
                r_cov <= rounded;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_sample <= scaled_sat;
        end
        if (i_cmd.pred) begin
            r_pm <= pm_sat;
        end
        if (i_cmd.den) begin
            r_den      <= den_sum;
            r_den_zero <= (den_sum == '0);
            r_rem      <= REM_W'(r_pm);
            r_quo      <= '0;
            r_step     <= '0;
            r_dir      <= (r_sample >= r_est);
            r_diff     <= (r_sample >= r_est) ? (r_sample - r_est) : (r_est - r_sample);
        end
        if (i_cmd.div_step) begin
            r_quo  <= {r_quo[GAIN_W-2:0], ge};
            r_rem  <= {rem_keep[REM_W-2:0], 1'b0};
            r_step <= r_step + STEP_W'(1);
        end
        if (i_cmd.mulx) begin
            r_gain <= gain_eff;
            r_prod <= product;
        end
        if (i_cmd.updx) begin
            r_prod <= product;
        end
        if (i_cmd.load_out) begin
            r_out_est  <= r_est;
            r_out_gain <= r_gain;
        end
    end

    assign o_estimate = r_out_est;
    assign o_gain     = r_out_gain;

endmodule

`default_nettype wire

@@ sv/skf_ctrl.sv @@
// skf_ctrl: sequencing state machine and output valid flag of the filter.
// Depends on skf_pkg; issues t_cmd to skf_datapath and reads its t_status.
`default_nettype none

module skf_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    input  wire skf_pkg::t_status i_status,
    output skf_pkg::t_cmd         o_cmd
);
    import skf_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    t_cmd   cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load_in = 1'b1;
                    n_state     = S_PRED;
                end
            end
            S_PRED: begin
                cmd.pred = 1'b1;
                n_state  = S_DEN;
            end
            S_DEN: begin
                cmd.den = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_MULX;
                end
            end
            S_MULX: begin
                cmd.mulx = 1'b1;
                n_state  = S_UPDX;
            end
            S_UPDX: begin
                cmd.updx = 1'b1;
                n_state  = S_UPDP;
            end
            S_UPDP: begin
                cmd.updp = 1'b1;
                n_state  = S_LOAD;
            end
            S_LOAD: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    cmd.load_out = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_PRED))
        else $error("accepted word did not start prediction");

    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && i_status.div_last) |=> (r_state == S_MULX))
        else $error("divider did not hand over to multiply");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |=> r_out_valid)
        else $error("output load did not raise valid");

    a_load_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD && r_out_valid && !i_out_ready) |=> (r_state == S_LOAD))
        else $error("result overwrote an untaken output word");

endmodule

`default_nettype wire

@@ sv/scalar_kalman_filter.sv @@
// scalar_kalman_filter: top level of the one-dimensional fixed-point Kalman filter.
// Depends on skf_pkg, skf_ctrl and skf_datapath.
//
//   Channel   Handshake                  Payload
//   input     i_in_valid / o_in_ready    i_measurement  (16 b, raw sample)
//   output    o_out_valid / i_out_ready  o_estimate (32 b, Q16.16), o_gain (17 b, Q0.16)
//   config    i_cfg_we (no wait)         i_cfg_index, i_cfg_data (32 b)
//
// Each word runs from acceptance to result loading through prediction,
// denominator, 17 steps of the restoring gain divider, then two passes through
// the shared 17x32 multiplier and the output load.
// The next word is accepted the cycle after the result is loaded, while that
// result may still sit in the output register.
// A stalled output holds the finished word in the load state until the output
// register frees up. Reset is synchronous, active low: estimate and covariance
// go to zero, process noise to 6554 and measurement noise to 65536.
`default_nettype none

module scalar_kalman_filter (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration
    input  wire logic                          i_cfg_we,
    input  wire logic [skf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [skf_pkg::DATA_W-1:0]    i_cfg_data,
    // input word
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [skf_pkg::MEAS_W-1:0]    i_measurement,
    // output word
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic      [skf_pkg::DATA_W-1:0]    o_estimate,
    output logic      [skf_pkg::GAIN_W-1:0]    o_gain
);
    import skf_pkg::*;

    // commands from the sequencer, status back from the datapath
    t_cmd    cmd;
    t_status status;

    // Sequencer: steps each word through predict, divide, multiply, update
    skf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Datapath: holds Q, R, estimate, covariance and the output word
    skf_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_measurement (i_measurement),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_estimate    (o_estimate),
        .o_gain        (o_gain)
    );

endmodule

`default_nettype wire

@@ verif/tb_scalar_kalman_filter.sv @@
// tb_scalar_kalman_filter: self-checking bench for the scalar Kalman filter, with
// a directed table, random phases under back-pressure and a fixed-point predictor.
// Depends on skf_pkg and scalar_kalman_filter.
`default_nettype none

module tb_scalar_kalman_filter;
    import skf_pkg::*;

    // Give up long after the slowest legal run would have finished
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 40;
    localparam int SEGMENTS     = 4;
    localparam int SEG_WORDS    = 142;

    // Predictor constants, kept at 64 bits so no product can overflow
    localparam logic [63:0] UNITY     = 64'd1 << GAIN_BITS;
    localparam logic [63:0] ROUND_BIT = 64'd1 << (GAIN_BITS - 1);

    typedef struct packed {
        logic [DATA_W-1:0] estimate;
        logic [GAIN_W-1:0] gain;
    } t_kalman_out;

    typedef enum logic {
        ROW_WRITE,
        ROW_WORD
    } t_row_kind;

    // One directed row: a register write, or a sample with an optional literal result
    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  index;
        logic [DATA_W-1:0]     value;
        logic                  literal;
        logic [DATA_W-1:0]     estimate;
        logic [GAIN_W-1:0]     gain;
    } t_dir_row;

    localparam int DIR_ROWS = 24;
    localparam t_dir_row DIRECTED [DIR_ROWS] = '{
        // reset settings: Q=6554, R=65536, zero sample keeps the estimate at zero
        '{ROW_WORD,  CFG_PROCESS_NOISE, 32'h0000_0000, 1'b1, 32'h0000_0000, 17'd5958},
        '{ROW_WRITE, CFG_PROCESS_NOISE, 32'h0000_0000, 1'b0, 32'h0, 17'h0},
        '{ROW_WRITE, CFG_MEAS_NOISE,    32'h0000_0000, 1'b0, 32'h0, 17'h0},
        // R=0 with leftover covariance: gain of one clears the covariance
        '{ROW_WORD,  CFG_PROCESS_NOISE, 32'h0000_0000, 1'b1, 32'h0000_0000, 17'h1_0000},
        // zero denominator: gain zero, estimate frozen
        '{ROW_WORD,  CFG_PROCESS_NOISE, 32'h0000_FFFF, 1'b1, 32'h0000_0000, 17'h0},
        '{ROW_WORD,  CFG_PROCESS_NOISE, 32'h0000_0001, 1'b1, 32'h0000_0000, 17'h0},
        // tiny Q, then full-scale Q, with R=0: estimate snaps onto each sample
        '{ROW_WRITE, CFG_PROCESS_NOISE, 32'h0000_0001, 1'b0, 32'h0, 17'h0},
        '{ROW_WORD,  CFG_PROCESS_NOISE, 32'h0000_FFFF, 1'b1, 32'hFFFF_0000, 17'h1_0000},
        '{ROW_WORD,  CFG_PROCESS_NOISE, 32'h0000_0000, 1'b1, 32'h0000_0000, 17'h1_0000},
        '{ROW_WORD,  CFG_PROCESS_NOISE, 32'h0000_8000, 1'b1, 32'h8000_0000, 17'h1_0000},
        '{ROW_WRITE, CFG_PROCESS_NOISE, 32'hFFFF_FFFF, 1'b0, 32'h0, 17'h0},
        '{ROW_WORD,  CFG_PROCESS_NOISE, 32'h0000_5555, 1'b1, 32'h5555_0000, 17'h1_0000},
        // both noises at full scale: gain one half, then the covariance saturates
        '{ROW_WRITE, CFG_MEAS_NOISE,    32'hFFFF_FFFF, 1'b0, 32'h0, 17'h0},
        '{ROW_WORD,  CFG_PROCESS_NOISE, 32'h0000_AAAA, 1'b0, 32'h0, 17'h0},
        '{ROW_WORD,  CFG_PROCESS_NOISE, 32'h0000_FFFF, 1'b0, 32'h0, 17'h0},
        '{ROW_WORD,  CFG_PROCESS_NOISE, 32'h0000_0000, 1'b0, 32'h0, 17'h0},
        '{ROW_WRITE, CFG_PROCESS_NOISE, 32'h0000_0000, 1'b0, 32'h0, 17'h0},
        '{ROW_WRITE, CFG_MEAS_NOISE,    32'h0000_0001, 1'b0, 32'h0, 17'h0},
        '{ROW_WORD,  CFG_PROCESS_NOISE, 32'h0000_7FFF, 1'b0, 32'h0, 17'h0},
        // back to the reset settings
        '{ROW_WRITE, CFG_PROCESS_NOISE, 32'h0000_199A, 1'b0, 32'h0, 17'h0},
        '{ROW_WRITE, CFG_MEAS_NOISE,    32'h0001_0000, 1'b0, 32'h0, 17'h0},
        '{ROW_WORD,  CFG_PROCESS_NOISE, 32'h0000_1234, 1'b0, 32'h0, 17'h0},
        '{ROW_WORD,  CFG_PROCESS_NOISE, 32'h0000_0001, 1'b0, 32'h0, 17'h0},
        '{ROW_WORD,  CFG_PROCESS_NOISE, 32'h0000_FFFF, 1'b0, 32'h0, 17'h0}
    };

    // DUT signals; every input starts at a known value
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index   = CFG_PROCESS_NOISE;
    logic [DATA_W-1:0]    i_cfg_data    = '0;
    logic                 i_in_valid    = 1'b0;
    logic                 o_in_ready;
    logic [MEAS_W-1:0]    i_measurement = '0;
    logic                 o_out_valid;
    logic                 i_out_ready   = 1'b0;
    logic [DATA_W-1:0]    o_estimate;
    logic [GAIN_W-1:0]    o_gain;

    // Predictor state: its own copy of the filter state and the two noise registers
    logic [DATA_W-1:0] est_state;
    logic [DATA_W-1:0] cov_state;
    logic [DATA_W-1:0] q_noise;
    logic [DATA_W-1:0] r_noise;

    t_kalman_out expected_results[$];
    t_kalman_out head_result;
    int          mismatches     = 0;
    int          cycle_count    = 0;
    int          send_idle_pct  = 0;
    int          recv_idle_pct  = 0;

    scalar_kalman_filter u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_measurement(i_measurement),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_estimate   (o_estimate),
        .o_gain       (o_gain)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Clamp a wide value to the 32-bit unsigned range
    function automatic logic [63:0] clamp32(logic [63:0] v);
        return (v > DATA_MAX) ? DATA_MAX : v;
    endfunction

    // Advance the predicted filter by one sample and return the word it emits:
    // predict covariance, form the gain, pull the estimate toward the sample
    // (rounding half away from zero), shrink the covariance.
    function automatic t_kalman_out kalman_step(logic [MEAS_W-1:0] sample);
        logic [63:0] p_pred;
        logic [63:0] denom;
        logic [63:0] k;
        logic [63:0] target;
        logic [63:0] x;
        t_kalman_out res;
        p_pred = clamp32({32'b0, cov_state} + {32'b0, q_noise});
        denom  = p_pred + {32'b0, r_noise};
        k      = '0;
        if (denom != 0) begin
            k = (p_pred << GAIN_BITS) / denom;
            if (k > UNITY) begin
                k = UNITY;
            end
        end
        target = clamp32({48'b0, sample & SAMPLE_MASK} << FRAC_BITS);
        x      = {32'b0, est_state};
        if (target >= x) begin
            x = x + ((k * (target - x) + ROUND_BIT) >> GAIN_BITS);
        end else begin
            x = x - ((k * (x - target) + ROUND_BIT) >> GAIN_BITS);
        end
        est_state    = DATA_W'(clamp32(x));
        cov_state    = DATA_W'(clamp32(((UNITY - k) * p_pred + ROUND_BIT) >> GAIN_BITS));
        res.estimate = est_state;
        res.gain     = GAIN_W'(k);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("MISMATCH %s: got 0x%08h, want 0x%08h at cycle %0d",
                 what, got, want, cycle_count);
        mismatches++;
    endtask

    // Drop valid (if it is up) and hold until every predicted word has come out
    task automatic drain_results();
        if (i_in_valid) begin
            i_in_valid <= 1'b0;
        end
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Write one register while the filter is idle, mirror it in the predictor
    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [DATA_W-1:0] value);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        case (index)
            CFG_PROCESS_NOISE: q_noise = value;
            CFG_MEAS_NOISE:    r_noise = value;
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Offer one sample, wait for the handshake, then queue what it must produce.
    // Valid is left high on return so the next word can follow back to back.
    task automatic send_word(input logic [MEAS_W-1:0] sample, input logic literal,
                             input t_kalman_out literal_out);
        t_kalman_out predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_measurement <= sample;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        predicted = kalman_step(sample);
        expected_results.push_back(literal ? literal_out : predicted);
    endtask

    // Random noise setting, extremes included
    function automatic logic [DATA_W-1:0] draw_noise();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            2:       return DATA_W'($urandom_range(1, 262144));
            3:       return DATA_W'(1) << $urandom_range(DATA_W - 1);
            4:       return MEAS_NOISE_RESET;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    // Mostly a noisy steady level, with full-range words, rails and bit flips mixed in
    function automatic logic [MEAS_W-1:0] draw_sample(logic [MEAS_W-1:0] level);
        int pick;
        pick = $urandom_range(99);
        if (pick < 65) begin
            return level + MEAS_W'($urandom_range(64)) - MEAS_W'(32);
        end else if (pick < 80) begin
            return MEAS_W'($urandom);
        end else if (pick < 90) begin
            return $urandom_range(1) ? '1 : '0;
        end
        return level ^ (MEAS_W'(1) << $urandom_range(MEAS_W - 1));
    endfunction

    // Output side: check each accepted word against the oldest prediction,
    // then pick the next ready from the current stall rate.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("word with nothing pending", o_estimate, '0);
            end else begin
                head_result = expected_results.pop_front();
                if (o_estimate !== head_result.estimate) begin
                    report_mismatch("estimate", o_estimate, head_result.estimate);
                end
                if (o_gain !== head_result.gain) begin
                    report_mismatch("gain", DATA_W'(o_gain), DATA_W'(head_result.gain));
                end
            end
        end
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        logic [MEAS_W-1:0] level;
        t_kalman_out       literal_out;

        // Mirror the reset values of the filter
        est_state = '0;
        cov_state = '0;
        q_noise   = PROCESS_NOISE_RESET;
        r_noise   = MEAS_NOISE_RESET;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: no idling on the sender, receiver always ready
        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].kind == ROW_WRITE) begin
                write_register(DIRECTED[i].index, DIRECTED[i].value);
            end else begin
                literal_out.estimate = DIRECTED[i].estimate;
                literal_out.gain     = DIRECTED[i].gain;
                send_word(MEAS_W'(DIRECTED[i].value), DIRECTED[i].literal, literal_out);
            end
        end

        // Random phases: receiver-heavy idling, then sender-heavy, then none.
        // Each segment starts from a fresh pair of noise settings.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 38;
                    recv_idle_pct = 77;
                end
                1: begin
                    send_idle_pct = 77;
                    recv_idle_pct = 38;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int seg = 0; seg < SEGMENTS; seg++) begin
                write_register(CFG_PROCESS_NOISE, draw_noise());
                write_register(CFG_MEAS_NOISE, draw_noise());
                level = MEAS_W'($urandom);
                for (int n = 0; n < SEG_WORDS; n++) begin
                    // Hold the sender once until the filter has emptied out
                    if (phase == 0 && seg == 1 && n == SEG_WORDS / 2) begin
                        drain_results();
                    end
                    if ($urandom_range(99) < 3) begin
                        level = MEAS_W'($urandom);
                    end
                    send_word(draw_sample(level), 1'b0, '0);
                end
            end
        end

        // Let the last words out, then watch for strays
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
